// File: sv/lpu_pkg.sv
// ----------------------------------------------------------------------------
// lpu_pkg
// Shared types, constants and fixed-point helpers for the lens point
// undistortion pipeline.
// ----------------------------------------------------------------------------
package lpu_pkg;

    localparam int ITERATIONS_DEF = 10;
    localparam int DIV_STEPS      = 32;
    localparam int CFG_IDX_W      = 4;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FOCAL_X     = 4'd0,
        REG_FOCAL_Y     = 4'd1,
        REG_CENTER_X    = 4'd2,
        REG_CENTER_Y    = 4'd3,
        REG_RADIAL_K1   = 4'd4,
        REG_RADIAL_K2   = 4'd5,
        REG_RADIAL_K3   = 4'd6,
        REG_TANGENTIAL  = 4'd7
    } cfg_reg_t;

    typedef logic signed [31:0] q32_t;
    typedef logic signed [32:0] diff_t;
    typedef logic signed [40:0] rnd_t;
    typedef logic signed [43:0] wide_t;

    typedef struct packed {
        logic [63:0] m;
        logic        neg;
    } prod_t;

    typedef struct packed {
        q32_t v;
        logic ovf;
    } sat_t;

    typedef struct packed {
        q32_t k1;
        q32_t k2;
        q32_t k3;
        q32_t p1;
        q32_t p2;
    } coef_t;

    typedef struct packed {
        q32_t xd;
        q32_t yd;
        logic flag;
    } ctx_t;

    localparam q32_t  Q32_MAX = 32'sh7fffffff;
    localparam q32_t  Q32_MIN = 32'sh80000000;
    localparam wide_t W_MAX   = 44'sd2147483647;
    localparam wide_t W_MIN   = -44'sd2147483648;
    localparam wide_t ONE_Q28 = 44'sd268435456;

    function automatic logic [31:0] mag32(input q32_t v);
        mag32 = v[31] ? 32'(-v) : 32'(v);
    endfunction

    function automatic prod_t mulm(input q32_t a, input q32_t b);
        prod_t p;
        logic [31:0] ma;
        logic [31:0] mb;
        ma = mag32(a);
        mb = mag32(b);
        p.m = {32'd0, ma} * {32'd0, mb};
        p.neg = a[31] ^ b[31];
        mulm = p;
    endfunction

    // round half away from zero; sel24 picks a shift of 24, else 28
    function automatic rnd_t rnd_q(input prod_t p, input logic sel24);
        logic [63:0] r;
        if (sel24)
        begin
            r = (p.m + 64'd8388608) >> 24;
        end
        else
        begin
            r = (p.m + 64'd134217728) >> 28;
        end
        rnd_q = p.neg ? -$signed({2'b00, r[38:0]}) : $signed({2'b00, r[38:0]});
    endfunction

    function automatic sat_t sat32(input wide_t v);
        sat_t r;
        if (v > W_MAX)
        begin
            r.v   = Q32_MAX;
            r.ovf = 1'b1;
        end
        else if (v < W_MIN)
        begin
            r.v   = Q32_MIN;
            r.ovf = 1'b1;
        end
        else
        begin
            r.v   = v[31:0];
            r.ovf = 1'b0;
        end
        sat32 = r;
    endfunction

endpackage

// File: sv/lpu_ifs.sv
// ----------------------------------------------------------------------------
// lpu_ifs
// Valid/ready channels: pixel requests, results and register writes.
// ----------------------------------------------------------------------------
interface lpu_pixel_if;
    import lpu_pkg::*;
    logic valid;
    logic ready;
    q32_t pixel_x;
    q32_t pixel_y;
    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface lpu_result_if;
    import lpu_pkg::*;
    logic valid;
    logic ready;
    q32_t undist_x;
    q32_t undist_y;
    logic saturated;
    modport source (output valid, output undist_x, output undist_y, output saturated,
                    input ready);
    modport sink (input valid, input undist_x, input undist_y, input saturated,
                  output ready);
endinterface

interface lpu_cfg_if;
    import lpu_pkg::*;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [63:0]          data;
    modport source (output valid, output index, output data, input ready);
    modport sink (input valid, input index, input data, output ready);
endinterface

// File: sv/lens_point_undistortion.sv
// ----------------------------------------------------------------------------
// lens_point_undistortion
// Iterative Brown-Conrady point undistortion, fully pipelined.
// Throughput: one point per cycle while not stalled; each iteration is a 9-stage
// datapath followed by a 34-stage bit-per-stage divider.
// The whole pipeline advances when the result register is empty or taken.
// Reset clears valid bits and loads focal lengths of 1.0, all else 0.
// ----------------------------------------------------------------------------
module lens_point_undistortion #(
    parameter int ITERATIONS = lpu_pkg::ITERATIONS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    lpu_cfg_if.sink      cfg,
    lpu_pixel_if.sink    pix,
    lpu_result_if.source res
);
    import lpu_pkg::*;

    logic [30:0] focal_x_reg, focal_y_reg;
    q32_t        center_x_reg, center_y_reg;
    q32_t        k1_reg, k2_reg, k3_reg;
    logic [63:0] tang_reg;
    coef_t       coef;

    logic adv;

    logic  n_v_reg;
    diff_t n_dx_reg, n_dy_reg;

    logic norm_v;
    q32_t norm_x, norm_y;
    logic norm_side, norm_ovf_a, norm_ovf_b;

    logic it_v   [0:ITERATIONS];
    q32_t it_x   [0:ITERATIONS];
    q32_t it_y   [0:ITERATIONS];
    ctx_t it_ctx [0:ITERATIONS];

    logic  m_v_reg, m_flag_reg;
    prod_t m_px_reg, m_py_reg;
    sat_t  ux_next, uy_next;

    logic res_valid_reg, res_flag_reg;
    q32_t res_x_reg, res_y_reg;

    assign cfg.ready = 1'b1;
    assign adv       = !res_valid_reg || res.ready;
    assign pix.ready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            focal_x_reg  <= 31'd65536;
            focal_y_reg  <= 31'd65536;
            center_x_reg <= '0;
            center_y_reg <= '0;
            k1_reg       <= '0;
            k2_reg       <= '0;
            k3_reg       <= '0;
            tang_reg     <= '0;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_FOCAL_X:    focal_x_reg  <= cfg.data[30:0];
                REG_FOCAL_Y:    focal_y_reg  <= cfg.data[30:0];
                REG_CENTER_X:   center_x_reg <= cfg.data[31:0];
                REG_CENTER_Y:   center_y_reg <= cfg.data[31:0];
                REG_RADIAL_K1:  k1_reg       <= cfg.data[31:0];
                REG_RADIAL_K2:  k2_reg       <= cfg.data[31:0];
                REG_RADIAL_K3:  k3_reg       <= cfg.data[31:0];
                REG_TANGENTIAL: tang_reg     <= cfg.data;
                default: ;
            endcase
        end
    end

    assign coef = '{k1: k1_reg, k2: k2_reg, k3: k3_reg,
                    p1: tang_reg[31:0], p2: tang_reg[63:32]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            n_v_reg       <= 1'b0;
            m_v_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            n_v_reg       <= pix.valid;
            m_v_reg       <= it_v[ITERATIONS];
            res_valid_reg <= m_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            n_dx_reg   <= 33'(pix.pixel_x) - 33'(center_x_reg);
            n_dy_reg   <= 33'(pix.pixel_y) - 33'(center_y_reg);
            m_flag_reg <= it_ctx[ITERATIONS].flag;
            m_px_reg   <= mulm(it_x[ITERATIONS], q32_t'({1'b0, focal_x_reg}));
            m_py_reg   <= mulm(it_y[ITERATIONS], q32_t'({1'b0, focal_y_reg}));
            res_x_reg    <= ux_next.v;
            res_y_reg    <= uy_next.v;
            res_flag_reg <= m_flag_reg | ux_next.ovf | uy_next.ovf;
        end
    end

    lpu_div #(.SW(1)) u_norm (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (n_v_reg),
        .num_a     (n_dx_reg),
        .num_b     (n_dy_reg),
        .den_a     (q32_t'({1'b0, focal_x_reg})),
        .den_b     (q32_t'({1'b0, focal_y_reg})),
        .side_in   (1'b0),
        .out_valid (norm_v),
        .q_a       (norm_x),
        .q_b       (norm_y),
        .ovf_a     (norm_ovf_a),
        .ovf_b     (norm_ovf_b),
        .side_out  (norm_side)
    );

    assign it_v[0]   = norm_v;
    assign it_x[0]   = norm_x;
    assign it_y[0]   = norm_y;
    assign it_ctx[0] = '{xd: norm_x, yd: norm_y, flag: norm_side | norm_ovf_a | norm_ovf_b};

    for (genvar g = 0; g < ITERATIONS; g++)
    begin : g_iter
        lpu_iter u_iter (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (adv),
            .coef      (coef),
            .in_valid  (it_v[g]),
            .in_x      (it_x[g]),
            .in_y      (it_y[g]),
            .in_ctx    (it_ctx[g]),
            .out_valid (it_v[g+1]),
            .out_x     (it_x[g+1]),
            .out_y     (it_y[g+1]),
            .out_ctx   (it_ctx[g+1])
        );
    end

    always_comb
    begin
        ux_next = sat32(44'(rnd_q(m_px_reg, 1'b0)) + 44'(center_x_reg));
        uy_next = sat32(44'(rnd_q(m_py_reg, 1'b0)) + 44'(center_y_reg));
    end

    assign res.valid     = res_valid_reg;
    assign res.undist_x  = res_x_reg;
    assign res.undist_y  = res_y_reg;
    assign res.saturated = res_flag_reg;

endmodule

// File: sv/lpu_div.sv
// ----------------------------------------------------------------------------
// lpu_div
// Two-lane pipelined divider: (num << 28) / den, truncated toward zero,
// saturated to signed 32 bits. One quotient bit per stage.
// ----------------------------------------------------------------------------
module lpu_div #(
    parameter int SW = 1
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 in_valid,
    input  lpu_pkg::diff_t       num_a,
    input  lpu_pkg::diff_t       num_b,
    input  lpu_pkg::q32_t        den_a,
    input  lpu_pkg::q32_t        den_b,
    input  logic [SW-1:0]        side_in,
    output logic                 out_valid,
    output lpu_pkg::q32_t        q_a,
    output lpu_pkg::q32_t        q_b,
    output logic                 ovf_a,
    output logic                 ovf_b,
    output logic [SW-1:0]        side_out
);
    import lpu_pkg::*;

    typedef struct packed {
        logic [32:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic [31:0] d;
        logic        neg;
        logic        fix;
        q32_t        fixv;
        logic        ovf;
    } lane_t;

    function automatic lane_t lane_init(input diff_t num, input q32_t den);
        lane_t       l;
        logic [32:0] mn;
        logic [31:0] md;
        mn = num[32] ? 33'(-num) : 33'(num);
        md = mag32(den);
        l.rem  = {4'd0, mn[32:4]};
        l.low  = {mn[3:0], 28'd0};
        l.quo  = '0;
        l.d    = md;
        l.neg  = num[32] ^ den[31];
        l.fix  = 1'b0;
        l.fixv = '0;
        l.ovf  = 1'b0;
        if (md == '0)
        begin
            l.fix  = 1'b1;
            l.ovf  = 1'b1;
            l.fixv = (mn == '0) ? q32_t'(0) : (num[32] ? Q32_MIN : Q32_MAX);
        end
        else if ({3'd0, mn} >= {md, 4'd0})
        begin
            l.fix  = 1'b1;
            l.ovf  = 1'b1;
            l.fixv = l.neg ? Q32_MIN : Q32_MAX;
        end
        lane_init = l;
    endfunction

    function automatic lane_t lane_step(input lane_t li);
        lane_t       l;
        logic [32:0] t;
        logic        qb;
        l  = li;
        t  = {li.rem[31:0], li.low[31]};
        qb = (t >= {1'b0, li.d});
        l.rem = qb ? (t - {1'b0, li.d}) : t;
        l.low = {li.low[30:0], 1'b0};
        l.quo = {li.quo[30:0], qb};
        lane_step = l;
    endfunction

    function automatic sat_t lane_final(input lane_t l);
        sat_t r;
        r.v   = l.fixv;
        r.ovf = l.ovf;
        if (!l.fix)
        begin
            if (!l.neg)
            begin
                r.v   = l.quo[31] ? Q32_MAX : q32_t'(l.quo);
                r.ovf = l.quo[31];
            end
            else
            begin
                r.v   = (l.quo > 32'h80000000) ? Q32_MIN : q32_t'(32'd0 - l.quo);
                r.ovf = (l.quo > 32'h80000000);
            end
        end
        lane_final = r;
    endfunction

    logic          v_reg [0:DIV_STEPS];
    lane_t         a_reg [0:DIV_STEPS];
    lane_t         b_reg [0:DIV_STEPS];
    logic [SW-1:0] s_reg [0:DIV_STEPS];
    logic          o_v_reg;
    sat_t          o_a_reg;
    sat_t          o_b_reg;
    logic [SW-1:0] o_s_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i <= DIV_STEPS; i++)
            begin
                v_reg[i] <= 1'b0;
            end
            o_v_reg <= 1'b0;
        end
        else if (en)
        begin
            v_reg[0] <= in_valid;
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                v_reg[i] <= v_reg[i-1];
            end
            o_v_reg <= v_reg[DIV_STEPS];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_reg[0] <= lane_init(num_a, den_a);
            b_reg[0] <= lane_init(num_b, den_b);
            s_reg[0] <= side_in;
            for (int i = 1; i <= DIV_STEPS; i++)
            begin
                a_reg[i] <= lane_step(a_reg[i-1]);
                b_reg[i] <= lane_step(b_reg[i-1]);
                s_reg[i] <= s_reg[i-1];
            end
            o_a_reg <= lane_final(a_reg[DIV_STEPS]);
            o_b_reg <= lane_final(b_reg[DIV_STEPS]);
            o_s_reg <= s_reg[DIV_STEPS];
        end
    end

    assign out_valid = o_v_reg;
    assign q_a       = o_a_reg.v;
    assign q_b       = o_b_reg.v;
    assign ovf_a     = o_a_reg.ovf;
    assign ovf_b     = o_b_reg.ovf;
    assign side_out  = o_s_reg;

endmodule

// File: sv/lpu_iter.sv
// ----------------------------------------------------------------------------
// lpu_iter
// One pipelined Brown-Conrady inversion step: distortion terms, radial
// divisor, then its own two-lane divider with the radial divisor on both lanes.
// ----------------------------------------------------------------------------
module lpu_iter (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           en,
    input  lpu_pkg::coef_t coef,
    input  logic           in_valid,
    input  lpu_pkg::q32_t  in_x,
    input  lpu_pkg::q32_t  in_y,
    input  lpu_pkg::ctx_t  in_ctx,
    output logic           out_valid,
    output lpu_pkg::q32_t  out_x,
    output lpu_pkg::q32_t  out_y,
    output lpu_pkg::ctx_t  out_ctx
);
    import lpu_pkg::*;

    logic  a_v_reg, b_v_reg, c_v_reg, d_v_reg, e_v_reg, f_v_reg, g_v_reg, h_v_reg, i_v_reg;
    ctx_t  a_ctx_reg, b_ctx_reg, c_ctx_reg, d_ctx_reg, e_ctx_reg;
    ctx_t  f_ctx_reg, g_ctx_reg, h_ctx_reg, i_ctx_reg;
    prod_t a_pxx_reg, a_pyy_reg, a_pxy_reg;
    q32_t  b_sqx_reg, b_sqy_reg, b_xy_reg;
    q32_t  c_r2_reg, c_sqx_reg, c_sqy_reg, c_xy_reg;
    q32_t  d_r2_reg, d_tx_reg, d_ty_reg, d_xy_reg;
    prod_t d_pr4_reg, d_pk1_reg;
    q32_t  e_r2_reg, e_r4_reg;
    rnd_t  e_t1_reg;
    prod_t e_pa_reg, e_pb_reg, e_pc_reg, e_pd_reg;
    rnd_t  f_t1_reg;
    prod_t f_pr6_reg, f_pk2_reg;
    q32_t  f_dx_reg, f_dy_reg;
    rnd_t  g_t1_reg, g_t2_reg;
    q32_t  g_r6_reg, g_dx_reg, g_dy_reg;
    wide_t h_tsum_reg;
    prod_t h_pk3_reg;
    q32_t  h_dx_reg, h_dy_reg;
    q32_t  i_radial_reg;
    diff_t i_nx_reg, i_ny_reg;

    sat_t b_sqx_next, b_sqy_next, b_xy_next, c_r2_next, d_tx_next, d_ty_next;
    sat_t e_r4_next, f_dx_next, f_dy_next, g_r6_next, i_radial_next;

    ctx_t div_side;
    logic div_ovf_a, div_ovf_b;

    always_comb
    begin
        b_sqx_next = sat32(44'(rnd_q(a_pxx_reg, 1'b0)));
        b_sqy_next = sat32(44'(rnd_q(a_pyy_reg, 1'b0)));
        b_xy_next  = sat32(44'(rnd_q(a_pxy_reg, 1'b0)));
        c_r2_next  = sat32(44'(b_sqx_reg) + 44'(b_sqy_reg));
        d_tx_next  = sat32(44'(c_r2_reg) + (44'(c_sqx_reg) <<< 1));
        d_ty_next  = sat32(44'(c_r2_reg) + (44'(c_sqy_reg) <<< 1));
        e_r4_next  = sat32(44'(rnd_q(d_pr4_reg, 1'b0)));
        f_dx_next  = sat32((44'(rnd_q(e_pa_reg, 1'b1)) <<< 1) + 44'(rnd_q(e_pb_reg, 1'b1)));
        f_dy_next  = sat32(44'(rnd_q(e_pc_reg, 1'b1)) + (44'(rnd_q(e_pd_reg, 1'b1)) <<< 1));
        g_r6_next  = sat32(44'(rnd_q(f_pr6_reg, 1'b0)));
        i_radial_next = sat32(ONE_Q28 + h_tsum_reg + 44'(rnd_q(h_pk3_reg, 1'b1)));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_v_reg <= 1'b0;
            b_v_reg <= 1'b0;
            c_v_reg <= 1'b0;
            d_v_reg <= 1'b0;
            e_v_reg <= 1'b0;
            f_v_reg <= 1'b0;
            g_v_reg <= 1'b0;
            h_v_reg <= 1'b0;
            i_v_reg <= 1'b0;
        end
        else if (en)
        begin
            a_v_reg <= in_valid;
            b_v_reg <= a_v_reg;
            c_v_reg <= b_v_reg;
            d_v_reg <= c_v_reg;
            e_v_reg <= d_v_reg;
            f_v_reg <= e_v_reg;
            g_v_reg <= f_v_reg;
            h_v_reg <= g_v_reg;
            i_v_reg <= h_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_ctx_reg <= in_ctx;
            a_pxx_reg <= mulm(in_x, in_x);
            a_pyy_reg <= mulm(in_y, in_y);
            a_pxy_reg <= mulm(in_x, in_y);

            b_ctx_reg      <= '{xd: a_ctx_reg.xd, yd: a_ctx_reg.yd,
                                flag: a_ctx_reg.flag | b_sqx_next.ovf | b_sqy_next.ovf
                                      | b_xy_next.ovf};
            b_sqx_reg      <= b_sqx_next.v;
            b_sqy_reg      <= b_sqy_next.v;
            b_xy_reg       <= b_xy_next.v;

            c_ctx_reg      <= '{xd: b_ctx_reg.xd, yd: b_ctx_reg.yd,
                                flag: b_ctx_reg.flag | c_r2_next.ovf};
            c_r2_reg       <= c_r2_next.v;
            c_sqx_reg      <= b_sqx_reg;
            c_sqy_reg      <= b_sqy_reg;
            c_xy_reg       <= b_xy_reg;

            d_ctx_reg      <= '{xd: c_ctx_reg.xd, yd: c_ctx_reg.yd,
                                flag: c_ctx_reg.flag | d_tx_next.ovf | d_ty_next.ovf};
            d_r2_reg       <= c_r2_reg;
            d_tx_reg       <= d_tx_next.v;
            d_ty_reg       <= d_ty_next.v;
            d_xy_reg       <= c_xy_reg;
            d_pr4_reg      <= mulm(c_r2_reg, c_r2_reg);
            d_pk1_reg      <= mulm(coef.k1, c_r2_reg);

            e_ctx_reg      <= '{xd: d_ctx_reg.xd, yd: d_ctx_reg.yd,
                                flag: d_ctx_reg.flag | e_r4_next.ovf};
            e_r2_reg       <= d_r2_reg;
            e_r4_reg       <= e_r4_next.v;
            e_t1_reg       <= rnd_q(d_pk1_reg, 1'b1);
            e_pa_reg       <= mulm(coef.p1, d_xy_reg);
            e_pb_reg       <= mulm(coef.p2, d_tx_reg);
            e_pc_reg       <= mulm(coef.p1, d_ty_reg);
            e_pd_reg       <= mulm(coef.p2, d_xy_reg);

            f_ctx_reg      <= '{xd: e_ctx_reg.xd, yd: e_ctx_reg.yd,
                                flag: e_ctx_reg.flag | f_dx_next.ovf | f_dy_next.ovf};
            f_t1_reg       <= e_t1_reg;
            f_pr6_reg      <= mulm(e_r4_reg, e_r2_reg);
            f_pk2_reg      <= mulm(coef.k2, e_r4_reg);
            f_dx_reg       <= f_dx_next.v;
            f_dy_reg       <= f_dy_next.v;

            g_ctx_reg      <= '{xd: f_ctx_reg.xd, yd: f_ctx_reg.yd,
                                flag: f_ctx_reg.flag | g_r6_next.ovf};
            g_t1_reg       <= f_t1_reg;
            g_t2_reg       <= rnd_q(f_pk2_reg, 1'b1);
            g_r6_reg       <= g_r6_next.v;
            g_dx_reg       <= f_dx_reg;
            g_dy_reg       <= f_dy_reg;

            h_ctx_reg      <= g_ctx_reg;
            h_tsum_reg     <= 44'(g_t1_reg) + 44'(g_t2_reg);
            h_pk3_reg      <= mulm(coef.k3, g_r6_reg);
            h_dx_reg       <= g_dx_reg;
            h_dy_reg       <= g_dy_reg;

            i_ctx_reg      <= '{xd: h_ctx_reg.xd, yd: h_ctx_reg.yd,
                                flag: h_ctx_reg.flag | i_radial_next.ovf};
            i_radial_reg   <= i_radial_next.v;
            i_nx_reg       <= 33'(h_ctx_reg.xd) - 33'(h_dx_reg);
            i_ny_reg       <= 33'(h_ctx_reg.yd) - 33'(h_dy_reg);
        end
    end

    lpu_div #(.SW($bits(ctx_t))) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (i_v_reg),
        .num_a     (i_nx_reg),
        .num_b     (i_ny_reg),
        .den_a     (i_radial_reg),
        .den_b     (i_radial_reg),
        .side_in   (i_ctx_reg),
        .out_valid (out_valid),
        .q_a       (out_x),
        .q_b       (out_y),
        .ovf_a     (div_ovf_a),
        .ovf_b     (div_ovf_b),
        .side_out  (div_side)
    );

    always_comb
    begin
        out_ctx      = div_side;
        out_ctx.flag = div_side.flag | div_ovf_a | div_ovf_b;
    end

endmodule

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lens_point_undistortion. Pixel requests go in from a
// queue, in bursts in some phases, and results leave through a stalling
// receiver. Each accepted request is run through a fixed-point model of the
// iterative Brown-Conrady inversion. Results are compared field by field, in
// order. Register settings change between phases while the block is idle.
// ----------------------------------------------------------------------------
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import lpu_pkg::*;

    localparam int                   DRAIN_CYCLES = 600;
    localparam int                   IDLE_LIMIT   = 20000;
    localparam int                   LONG_HOLD    = 3000;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 4'd8;
    localparam longint               ONE_FIX      = 64'sd268435456;
    localparam longint               MAX_S32      = 64'sd2147483647;
    localparam longint               MIN_S32      = -64'sd2147483648;

    typedef struct {
        q32_t x;
        q32_t y;
    } point_t;

    typedef struct {
        q32_t ux;
        q32_t uy;
        logic sat;
    } undist_t;

    logic clk;
    logic rst_n;

    lpu_cfg_if    cfg ();
    lpu_pixel_if  pix ();
    lpu_result_if res ();

    lens_point_undistortion dut (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .pix   (pix),
        .res   (res)
    );

    // shadow of the register file
    logic [30:0] focal_x;
    logic [30:0] focal_y;
    q32_t        center_x;
    q32_t        center_y;
    q32_t        radial_k1;
    q32_t        radial_k2;
    q32_t        radial_k3;
    logic [63:0] tangential;

    point_t  pending_points[$];
    undist_t expected_points[$];

    int  errors;
    int  n_requests;
    int  n_results;
    int  n_flagged;
    int  n_cfg_writes;
    int  idle_cycles;
    bit  pix_taken;
    int  burst_left;
    int  gap_left;
    int  send_mode;
    int  stall_mode;
    bit  long_hold_req;
    int  hold_left;

    always
    begin
        clk = 1'b1;
        #5;
        clk = 1'b0;
        #5;
    end

    // ---------------- fixed-point model ----------------
    function automatic longint clamp32(input longint v, inout bit f);
        if (v > MAX_S32)
        begin
            f = 1'b1;
            return MAX_S32;
        end
        if (v < MIN_S32)
        begin
            f = 1'b1;
            return MIN_S32;
        end
        return v;
    endfunction

    function automatic longint abs64(input longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic longint mul_round(input longint a, input longint b, input int s);
        longint unsigned m;
        m = longint'(abs64(a)) * longint'(abs64(b));
        m = (m + (64'd1 << (s - 1))) >> s;
        return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
    endfunction

    function automatic longint div_fix(input longint num, input longint den, inout bit f);
        longint unsigned q;
        longint          sq;
        if (den == 0)
        begin
            f = 1'b1;
            return (num > 0) ? MAX_S32 : ((num < 0) ? MIN_S32 : 0);
        end
        q  = (longint'(abs64(num)) << 28) / longint'(abs64(den));
        sq = ((num < 0) != (den < 0)) ? -longint'(q) : longint'(q);
        return clamp32(sq, f);
    endfunction

    function automatic undist_t undistort_point(input point_t p);
        undist_t r;
        bit      f;
        longint  fx, fy, cx, cy, k1, k2, k3, p1, p2;
        longint  xd, yd, x, y;
        longint  sqx, sqy, xy, r2, r4, r6, rad, tx, ty, dx, dy;
        f  = 1'b0;
        fx = longint'(focal_x);
        fy = longint'(focal_y);
        cx = longint'(center_x);
        cy = longint'(center_y);
        k1 = longint'(radial_k1);
        k2 = longint'(radial_k2);
        k3 = longint'(radial_k3);
        p1 = longint'($signed(tangential[31:0]));
        p2 = longint'($signed(tangential[63:32]));
        xd = div_fix(longint'(p.x) - cx, fx, f);
        yd = div_fix(longint'(p.y) - cy, fy, f);
        x  = xd;
        y  = yd;
        for (int i = 0; i < ITERATIONS_DEF; i++)
        begin
            sqx = clamp32(mul_round(x, x, 28), f);
            sqy = clamp32(mul_round(y, y, 28), f);
            xy  = clamp32(mul_round(x, y, 28), f);
            r2  = clamp32(sqx + sqy, f);
            r4  = clamp32(mul_round(r2, r2, 28), f);
            r6  = clamp32(mul_round(r4, r2, 28), f);
            rad = clamp32(ONE_FIX + mul_round(k1, r2, 24) + mul_round(k2, r4, 24)
                          + mul_round(k3, r6, 24), f);
            tx  = clamp32(r2 + 2 * sqx, f);
            ty  = clamp32(r2 + 2 * sqy, f);
            dx  = clamp32(2 * mul_round(p1, xy, 24) + mul_round(p2, tx, 24), f);
            dy  = clamp32(mul_round(p1, ty, 24) + 2 * mul_round(p2, xy, 24), f);
            x   = div_fix(xd - dx, rad, f);
            y   = div_fix(yd - dy, rad, f);
        end
        r.ux  = q32_t'(clamp32(mul_round(x, fx, 28) + cx, f));
        r.uy  = q32_t'(clamp32(mul_round(y, fy, 28) + cy, f));
        r.sat = f;
        return r;
    endfunction

    // ---------------- request driver ----------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pix.valid   <= 1'b0;
            pix.pixel_x <= '0;
            pix.pixel_y <= '0;
            burst_left  <= 0;
            gap_left    <= 0;
        end
        else if (!(pix.valid && !pix_taken))
        begin
            if (gap_left > 0)
            begin
                gap_left  <= gap_left - 1;
                pix.valid <= 1'b0;
            end
            else if (pending_points.size() == 0)
            begin
                pix.valid <= 1'b0;
            end
            else
            begin
                point_t p;
                p = pending_points.pop_front();
                pix.valid   <= 1'b1;
                pix.pixel_x <= p.x;
                pix.pixel_y <= p.y;
                if (send_mode != 0)
                begin
                    if (burst_left <= 1)
                    begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= $urandom_range(1, 12);
                    end
                    else
                    begin
                        burst_left <= burst_left - 1;
                    end
                end
            end
        end
    end

    // ---------------- result receiver ----------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res.ready <= 1'b0;
            hold_left <= 0;
        end
        else if (long_hold_req)
        begin
            long_hold_req = 1'b0;
            hold_left <= LONG_HOLD;
            res.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res.ready <= 1'b0;
        end
        else
        begin
            case (stall_mode)
                0: res.ready <= 1'b1;
                1: res.ready <= ($urandom_range(0, 9) >= 3);
                default: res.ready <= ($urandom_range(0, 31) == 0) ? 1'b0 : ~res.ready;
            endcase
        end
    end

    // ---------------- monitor and checker ----------------
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            bit moved;
            moved = 1'b0;
            pix_taken <= pix.valid && pix.ready;
            if (pix.valid && pix.ready)
            begin
                point_t p;
                p.x = pix.pixel_x;
                p.y = pix.pixel_y;
                expected_points.push_back(undistort_point(p));
                n_requests++;
                moved = 1'b1;
            end
            if (res.valid && res.ready)
            begin
                moved = 1'b1;
                n_results++;
                if (res.saturated)
                    n_flagged++;
                if (expected_points.size() == 0)
                begin
                    $error("unexpected result x=%0d y=%0d", res.undist_x, res.undist_y);
                    errors++;
                end
                else
                begin
                    undist_t e;
                    e = expected_points.pop_front();
                    if (res.undist_x !== e.ux)
                    begin
                        $error("undist_x expected %0d actual %0d", e.ux, res.undist_x);
                        errors++;
                    end
                    if (res.undist_y !== e.uy)
                    begin
                        $error("undist_y expected %0d actual %0d", e.uy, res.undist_y);
                        errors++;
                    end
                    if (res.saturated !== e.sat)
                    begin
                        $error("saturated expected %0b actual %0b", e.sat, res.saturated);
                        errors++;
                    end
                end
            end
            if (cfg.valid && cfg.ready)
                moved = 1'b1;
            idle_cycles = moved ? 0 : idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("timeout: no handshake for %0d cycles", IDLE_LIMIT);
                $display("Test completed with failures");
                $finish;
            end
        end
        else
        begin
            pix_taken <= 1'b0;
        end
    end

    // ---------------- sequencing ----------------
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] data);
        @(negedge clk);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= data;
        @(posedge clk);
        while (!cfg.ready)
            @(posedge clk);
        @(negedge clk);
        cfg.valid <= 1'b0;
        n_cfg_writes++;
        case (idx)
            REG_FOCAL_X:    focal_x    = data[30:0];
            REG_FOCAL_Y:    focal_y    = data[30:0];
            REG_CENTER_X:   center_x   = data[31:0];
            REG_CENTER_Y:   center_y   = data[31:0];
            REG_RADIAL_K1:  radial_k1  = data[31:0];
            REG_RADIAL_K2:  radial_k2  = data[31:0];
            REG_RADIAL_K3:  radial_k3  = data[31:0];
            REG_TANGENTIAL: tangential = data;
            default: ;
        endcase
    endtask

    task automatic wait_drained();
        while (pending_points.size() != 0 || pix.valid || expected_points.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    function automatic q32_t small_coef(input int span);
        return q32_t'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    task automatic random_config();
        write_reg(REG_FOCAL_X, (rand64() & 64'hffffffff80000000)
                  | (64'($urandom_range(200, 3000)) << 16) | (rand64() & 64'hffff));
        write_reg(REG_FOCAL_Y, 64'($urandom_range(200, 3000)) << 16 | 64'($urandom_range(0, 65535)));
        write_reg(REG_CENTER_X, {$urandom(), 32'($urandom_range(0, 1920)) << 16});
        write_reg(REG_CENTER_Y, 64'($urandom_range(0, 1080)) << 16);
        write_reg(REG_RADIAL_K1, 64'(small_coef(1 << 23)));
        write_reg(REG_RADIAL_K2, 64'(small_coef(1 << 21)));
        write_reg(REG_RADIAL_K3, 64'(small_coef(1 << 19)));
        write_reg(REG_TANGENTIAL, {small_coef(1 << 17), small_coef(1 << 17)});
    endtask

    function automatic point_t random_point();
        point_t p;
        int     sel;
        sel = $urandom_range(0, 9);
        if (sel < 7)
        begin
            p.x = center_x + (small_coef(1200) <<< 16) + q32_t'($urandom_range(0, 65535));
            p.y = center_y + (small_coef(900) <<< 16) + q32_t'($urandom_range(0, 65535));
        end
        else
        begin
            p.x = $urandom();
            p.y = $urandom();
        end
        return p;
    endfunction

    task automatic add_random(input int n);
        for (int i = 0; i < n; i++)
            pending_points.push_back(random_point());
    endtask

    task automatic add_point(input q32_t x, input q32_t y);
        point_t p;
        p.x = x;
        p.y = y;
        pending_points.push_back(p);
    endtask

    initial
    begin
        errors        = 0;
        n_requests    = 0;
        n_results     = 0;
        n_flagged     = 0;
        n_cfg_writes  = 0;
        idle_cycles   = 0;
        send_mode     = 0;
        stall_mode    = 0;
        long_hold_req = 1'b0;
        focal_x       = 31'd65536;
        focal_y       = 31'd65536;
        center_x      = '0;
        center_y      = '0;
        radial_k1     = '0;
        radial_k2     = '0;
        radial_k3     = '0;
        tangential    = '0;
        cfg.valid     = 1'b0;
        cfg.index     = '0;
        cfg.data      = '0;
        rst_n         = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset settings, field extremes
        add_point(32'sd0, 32'sd0);
        add_point(Q32_MAX, Q32_MAX);
        add_point(Q32_MIN, Q32_MIN);
        add_point(Q32_MAX, Q32_MIN);
        add_point(-32'sd1, 32'sd1);
        add_point(32'sd65536, -32'sd65536);
        add_point(32'sd131072, 32'sd32768);
        add_point(32'sh55555555, 32'shaaaaaaaa);
        wait_drained();

        // zero radial divisor: k1 = -1.0 at r^2 = 1.0
        write_reg(REG_RADIAL_K1, 64'hffffffff_ff000000);
        add_point(32'sd65536, 32'sd0);
        add_point(-32'sd65536, 32'sd0);
        add_point(32'sd0, 32'sd65536);
        add_point(32'sd46341, 32'sd46341);
        wait_drained();

        // zero focal length, register extremes, ignored index
        write_reg(REG_FOCAL_X, 64'h0);
        write_reg(REG_FOCAL_Y, 64'hffffffff_ffffffff);
        write_reg(REG_CENTER_X, 64'h7fffffff);
        write_reg(REG_CENTER_Y, 64'h80000000);
        write_reg(REG_RADIAL_K1, 64'h7fffffff);
        write_reg(REG_RADIAL_K2, 64'h80000000);
        write_reg(REG_RADIAL_K3, 64'h7fffffff);
        write_reg(REG_TANGENTIAL, 64'h80000000_7fffffff);
        write_reg(REG_UNUSED, 64'h12345);
        add_point(32'sd0, 32'sd0);
        add_point(Q32_MAX, Q32_MIN);
        add_point(Q32_MIN, Q32_MAX);
        add_point(32'sd12345, -32'sd999);
        send_mode  = 1;
        stall_mode = 1;
        add_random(40);
        wait_drained();

        write_reg(REG_FOCAL_X, 64'd1);
        write_reg(REG_FOCAL_Y, 64'd1);
        write_reg(REG_TANGENTIAL, 64'h7fffffff_80000000);
        add_random(40);
        wait_drained();

        // long receiver hold-off while the sender keeps offering
        random_config();
        send_mode     = 0;
        stall_mode    = 0;
        long_hold_req = 1'b1;
        add_random(700);
        add_point(32'sd0, 32'sd0);
        wait_drained();

        for (int ph = 0; ph < 3; ph++)
        begin
            random_config();
            send_mode  = ph % 2;
            stall_mode = ph;
            add_random(30);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("covered %0d requests, %0d results (%0d saturated), %0d register writes",
                 n_requests, n_results, n_flagged, n_cfg_writes);
        if (errors == 0 && expected_points.size() == 0)
        begin
            $display("Test completed successfully");
        end
        else
        begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
